// ===== rtl/nds_pkg.sv =====
// Shared types and constants for the nixie digit shift-out driver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package nds_pkg;

  // Display geometry
  localparam int TUBE_COUNT      = 6;
  localparam int DIGITS_PER_TUBE = 10;
  localparam int SHIFT_BYTES     = 8;
  localparam int VEC_W           = SHIFT_BYTES * 8;
  localparam int DIGIT_W         = 8;
  localparam int DOT_W           = 4;

  // Colon nibble codes; anything above COLON_BOTH holds the pair
  localparam logic [3:0] COLON_OFF    = 4'd0;
  localparam logic [3:0] COLON_BOTTOM = 4'd1;
  localparam logic [3:0] COLON_TOP    = 4'd2;
  localparam logic [3:0] COLON_BOTH   = 4'd3;

  // One stage of the shift chain
  typedef struct packed {
    logic dat;   // cathode bit
    logic vld;   // stage holds a live bit
    logic last;  // final bit of the update, latch strobe follows
  } cell_t;

  // Update handed from the front end to the shift chain
  typedef struct packed {
    logic [VEC_W-1:0] vec;
    logic [DOT_W-1:0] dots;
  } upd_t;

endpackage

// ===== rtl/nds_cell.sv =====
// One stage of the serial shift chain: parallel load or shift from neighbour.
// Depends on nds_pkg.
`timescale 1ns / 1ps

module nds_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load_en,
  input  logic          shift_en,
  input  nds_pkg::cell_t load_d,
  input  nds_pkg::cell_t prev_q,
  output nds_pkg::cell_t q
);
  import nds_pkg::*;

  cell_t q_r;
  cell_t q_nxt;

  // Load wins over shift; the chain is empty below the top when loading
  always_comb begin
    q_nxt = q_r;
    if (load_en) begin
      q_nxt = load_d;
    end else if (shift_en) begin
      q_nxt = prev_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ===== rtl/nds_front.sv =====
// Input stage: builds the one-hot cathode vector, applies the colon codes
// and holds one pending update for the shift chain. Depends on nds_pkg.
`timescale 1ns / 1ps

module nds_front (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [nds_pkg::TUBE_COUNT-1:0][nds_pkg::DIGIT_W-1:0] digits,
  input  logic [7:0]                              colon_code,
  input  logic                                    take,
  output logic                                    pend_vld,
  output nds_pkg::upd_t                           pend
);
  import nds_pkg::*;

  function automatic logic [1:0] apply_colon(input logic [1:0] pair,
                                             input logic [3:0] code);
    logic [1:0] res;
    case (code)
      COLON_OFF:    res = 2'b00;
      COLON_BOTTOM: res = 2'b01;
      COLON_TOP:    res = 2'b10;
      COLON_BOTH:   res = 2'b11;
      default:      res = pair;
    endcase
    return res;
  endfunction

  logic             pend_vld_r, pend_vld_nxt;
  upd_t             pend_r, pend_nxt;
  logic [DOT_W-1:0] dots_r, dots_nxt;
  logic [VEC_W-1:0] vec;
  logic             accept;

  assign in_stall = pend_vld_r;
  assign accept   = in_valid && !pend_vld_r;

  // One-hot per tube; position p carries tube TUBE_COUNT-1-p, codes above 9 blank
  always_comb begin
    vec = '0;
    for (int p = 0; p < TUBE_COUNT; p++) begin
      for (int d = 0; d < DIGITS_PER_TUBE; d++) begin
        if (p * DIGITS_PER_TUBE + d < VEC_W) begin
          vec[p * DIGITS_PER_TUBE + d] = (digits[TUBE_COUNT-1-p] == DIGIT_W'(d));
        end
      end
    end
  end

  // Dot levels: bit 3 left top, 2 left bottom, 1 right top, 0 right bottom
  always_comb begin
    dots_nxt = dots_r;
    if (accept) begin
      dots_nxt = {apply_colon(dots_r[3:2], colon_code[7:4]),
                  apply_colon(dots_r[1:0], colon_code[3:0])};
    end
  end

  // Pending slot
  always_comb begin
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    if (accept) begin
      pend_vld_nxt  = 1'b1;
      pend_nxt.vec  = vec;
      pend_nxt.dots = dots_nxt;
    end else if (take) begin
      pend_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      dots_r     <= '0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
      dots_r     <= dots_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

  assign pend_vld = pend_vld_r;
  assign pend     = pend_r;

endmodule

// ===== rtl/nixie_digit_shift_out_driver_unit.sv =====
// Top level of the nixie digit shift-out driver: front end plus shift chain.
// Depends on nds_pkg, nds_front and nds_cell.
`timescale 1ns / 1ps
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid, in_stall, in_digit_*, in_colon_code | update in
//  out     | out_valid, out_stall, out_serial_bit,         | one bit out
//          | out_last_bit, out_*_dot                       |
//
// Each update yields 64 transactions, one per cycle when out_stall is low,
// set by the 64-stage shift chain that drains one stage a cycle.
// An update first waits in the pending slot, so its first bit reaches the output
// through the pending slot and then the chain top stage; the next update is taken
// there while the chain drains and loads on the edge the last bit leaves, so
// updates stream with no gap. Reset clears the chain, pending slot and front-end
// dot levels (all off), not the output dots. Stalling holds the chain and outputs.

module nixie_digit_shift_out_driver_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_digit_hour_high,
  input  logic [7:0] in_digit_hour_low,
  input  logic [7:0] in_digit_minute_high,
  input  logic [7:0] in_digit_minute_low,
  input  logic [7:0] in_digit_second_high,
  input  logic [7:0] in_digit_second_low,
  input  logic [7:0] in_colon_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_serial_bit,
  output logic       out_last_bit,
  output logic       out_left_top_dot,
  output logic       out_left_bottom_dot,
  output logic       out_right_top_dot,
  output logic       out_right_bottom_dot
);
  import nds_pkg::*;

  logic [5:0][DIGIT_W-1:0]          all_digits;
  logic [TUBE_COUNT-1:0][DIGIT_W-1:0] digits;
  logic                             pend_vld;
  upd_t                             pend;
  logic                             advance;
  logic                             load;
  cell_t                            chain [VEC_W];
  cell_t                            top_q;
  logic [DOT_W-1:0]                 dots_out_r, dots_out_nxt;

  // Reorder so index n is tube n
  always_comb begin
    all_digits[0] = in_digit_hour_high;
    all_digits[1] = in_digit_hour_low;
    all_digits[2] = in_digit_minute_high;
    all_digits[3] = in_digit_minute_low;
    all_digits[4] = in_digit_second_high;
    all_digits[5] = in_digit_second_low;
    for (int t = 0; t < TUBE_COUNT; t++) begin
      digits[t] = all_digits[t];
    end
  end

  nds_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .digits     (digits),
    .colon_code (in_colon_code),
    .take       (load),
    .pend_vld   (pend_vld),
    .pend       (pend)
  );

  // Chain control: shift on each output transaction, reload when drained
  assign top_q   = chain[VEC_W-1];
  assign advance = top_q.vld && !out_stall;
  assign load    = pend_vld && (!top_q.vld || (advance && top_q.last));

  // Shift chain: stage VEC_W-1 drives the data line, bit 63 goes first
  for (genvar i = 0; i < VEC_W; i++) begin : g_chain
    cell_t load_d;
    cell_t prev_q;

    // data, live, last
    assign load_d = {pend.vec[i], 1'b1, (i == 0)};

    if (i == 0) begin : g_first
      assign prev_q = '0;
    end else begin : g_rest
      assign prev_q = chain[i-1];
    end

    nds_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .load_en  (load),
      .shift_en (advance),
      .load_d   (load_d),
      .prev_q   (prev_q),
      .q        (chain[i])
    );
  end

  // Dot levels are registered beside the chain and change as each update loads
  always_comb begin
    dots_out_nxt = dots_out_r;
    if (load) begin
      dots_out_nxt = pend.dots;
    end
  end

  always_ff @(posedge clk) begin
    dots_out_r <= dots_out_nxt;
  end

  assign out_valid            = top_q.vld;
  assign out_serial_bit       = top_q.dat;
  assign out_last_bit         = top_q.last;
  assign out_left_top_dot     = dots_out_r[3];
  assign out_left_bottom_dot  = dots_out_r[2];
  assign out_right_top_dot    = dots_out_r[1];
  assign out_right_bottom_dot = dots_out_r[0];

endmodule
